FILE: rtl/core/gshare_counter_predictor_core_defines.svh
// assertion macros shared by the predictor checker
`ifndef GSHARE_COUNTER_PREDICTOR_CORE_DEFINES_SVH
`define GSHARE_COUNTER_PREDICTOR_CORE_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define GCP_ASSERT_NOW(label, cond, conseq) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (conseq)) else $error("gcp check failed");

// next-cycle implication, checked on every clock outside reset
`define GCP_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error("gcp check failed");

`endif

FILE: rtl/core/gcp_pkg.sv
// shared constants and types of the gshare counter predictor
package gcp_pkg;

    localparam int INDEX_BITS   = 12;
    localparam int COUNTER_BITS = 8;
    localparam int TABLE_DEPTH  = 1 << INDEX_BITS;

    // configuration register widths
    localparam int MASK_W     = 12;
    localparam int CMAX_W     = 8;
    localparam int THR_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // stream payload widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    typedef logic [INDEX_BITS-1:0]   t_slot;
    typedef logic [COUNTER_BITS-1:0] t_ctr;

    localparam t_ctr CTR_CEIL    = '1;
    localparam t_ctr CLEAR_VALUE = COUNTER_BITS'(3);

    localparam logic [MASK_W-1:0] RESET_INDEX_MASK = MASK_W'(4095);
    localparam logic [CMAX_W-1:0] RESET_COUNTER_MAX = CMAX_W'(3);
    localparam logic [THR_W-1:0]  RESET_THRESHOLD   = THR_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INDEX_MASK      = 2'd0,
        CFG_COUNTER_MAX     = 2'd1,
        CFG_TAKEN_THRESHOLD = 2'd2
    } t_cfg_index;

    // request from the control logic to the counter memory
    typedef struct packed {
        logic  wr_en;
        t_slot wr_addr;
        t_ctr  wr_data;
        logic  rd_en;
        t_slot rd_addr;
    } t_ram_req;

endpackage

FILE: rtl/core/gshare_counter_predictor_core.sv
// gshare predictor top level: counter table, global history and stream handshakes
//
// input beats arrive on s_axis: pc and outcome in tdata, mode in tuser
// (0 predict only, 1 train). every input beat yields exactly one output beat
// on m_axis carrying the prediction and the counter value read before any
// update. configuration registers are written on the cfg channel, which is
// always ready; write them only while the block is idle.
// timing: an input beat is taken in the idle state, the counter table is read
// in that cycle and its data is ready in the next one; once the output register
// is free, the result is loaded into it and a train beat writes the counter back.
// an item is loaded into the output register before the next one is taken, set
// by the read-then-write of the single counter memory; the result passes the
// table's read register and then the output register. the output register lets
// the next input beat be taken while a result waits; if the receiver stalls, the
// following item is held after its table read until the output register frees up.
// reset: history and registers go to their reset values, then a clearing pass
// writes the reset ceiling into all 4096 counters, one per cycle; s_axis_tready
// stays low for the whole pass while cfg writes are still taken.
module gshare_counter_predictor_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [gcp_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [31:0] pc, [32] outcome
    input  logic                             s_axis_tuser,  // [0] mode
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [gcp_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // [0] predicted_taken, [8:1] counter_value
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gcp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gcp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } t_state;

    t_state r_state, n_state;

    // clearing pass address
    gcp_pkg::t_slot r_clr_addr, n_clr_addr;

    // configuration registers
    logic [gcp_pkg::MASK_W-1:0] r_index_mask;
    logic [gcp_pkg::CMAX_W-1:0] r_counter_max;
    logic [gcp_pkg::THR_W-1:0]  r_taken_threshold;

    // global branch history
    gcp_pkg::t_slot r_history, n_history;

    // item in flight between table read and write back
    gcp_pkg::t_slot r_slot;
    logic           r_mode;
    logic           r_outcome;

    // output register
    logic                r_out_valid, n_out_valid;
    logic                r_out_taken, n_out_taken;
    logic [gcp_pkg::CMAX_W-1:0] r_out_count, n_out_count;

    gcp_pkg::t_ram_req w_req;
    gcp_pkg::t_ctr     w_rd_data;
    gcp_pkg::t_ctr     w_ceil;
    gcp_pkg::t_ctr     w_new_ctr;
    gcp_pkg::t_slot    w_slot;
    logic              w_accept;
    logic              w_load;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // table index: pc xor history, masked to the table size in use
    assign w_slot = (s_axis_tdata[gcp_pkg::INDEX_BITS-1:0] ^ r_history)
                  & gcp_pkg::INDEX_BITS'(r_index_mask);

    // ceiling limited to what a counter can hold
    assign w_ceil = (r_counter_max > gcp_pkg::CMAX_W'(gcp_pkg::CTR_CEIL))
                  ? gcp_pkg::CTR_CEIL
                  : gcp_pkg::COUNTER_BITS'(r_counter_max);

    // saturating step; a counter above a lowered ceiling does not climb
    always_comb begin
        w_new_ctr = w_rd_data;
        if (r_outcome) begin
            if (w_rd_data < w_ceil) begin
                w_new_ctr = w_rd_data + gcp_pkg::COUNTER_BITS'(1);
            end
        end else begin
            if (w_rd_data != '0) begin
                w_new_ctr = w_rd_data - gcp_pkg::COUNTER_BITS'(1);
            end
        end
    end

    // the read data can leave only when the output register is free
    assign w_load = (r_state == ST_READ) && (!r_out_valid || m_axis_tready);

    // memory requests: clearing sweep, write back on train, read on accept
    always_comb begin
        w_req         = '0;
        w_req.rd_en   = w_accept;
        w_req.rd_addr = w_slot;
        if (r_state == ST_CLEAR) begin
            w_req.wr_en   = 1'b1;
            w_req.wr_addr = r_clr_addr;
            w_req.wr_data = gcp_pkg::CLEAR_VALUE;
        end else if (w_load && r_mode) begin
            w_req.wr_en   = 1'b1;
            w_req.wr_addr = r_slot;
            w_req.wr_data = w_new_ctr;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_history   = r_history;
        n_out_valid = r_out_valid;
        n_out_taken = r_out_taken;
        n_out_count = r_out_count;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + gcp_pkg::INDEX_BITS'(1);
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (w_load) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_taken = gcp_pkg::THR_W'(w_rd_data) > r_taken_threshold;
                    n_out_count = gcp_pkg::CMAX_W'(w_rd_data);
                    if (r_mode) begin
                        n_history = {r_history[gcp_pkg::INDEX_BITS-2:0], r_outcome};
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_CLEAR;
            r_clr_addr        <= '0;
            r_history         <= '0;
            r_out_valid       <= 1'b0;
            r_index_mask      <= gcp_pkg::RESET_INDEX_MASK;
            r_counter_max     <= gcp_pkg::RESET_COUNTER_MAX;
            r_taken_threshold <= gcp_pkg::RESET_THRESHOLD;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_history   <= n_history;
            r_out_valid <= n_out_valid;
            r_out_taken <= n_out_taken;
            r_out_count <= n_out_count;
            if (w_accept) begin
                r_slot    <= w_slot;
                r_mode    <= s_axis_tuser;
                r_outcome <= s_axis_tdata[32];
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (gcp_pkg::t_cfg_index'(i_cfg_index))
                    gcp_pkg::CFG_INDEX_MASK:      r_index_mask <= i_cfg_data;
                    gcp_pkg::CFG_COUNTER_MAX:     r_counter_max <= i_cfg_data[gcp_pkg::CMAX_W-1:0];
                    gcp_pkg::CFG_TAKEN_THRESHOLD: r_taken_threshold <= i_cfg_data[gcp_pkg::THR_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    gcp_counter_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (w_req),
        .o_rd_data (w_rd_data)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(gcp_pkg::M_TDATA_W - gcp_pkg::CMAX_W - 1){1'b0}},
                            r_out_count, r_out_taken};

endmodule

FILE: rtl/core/gcp_counter_ram.sv
// counter table: one write port, one registered read port
module gcp_counter_ram (
    input  logic              i_clk,
    input  gcp_pkg::t_ram_req i_req,
    output gcp_pkg::t_ctr     o_rd_data
);

    gcp_pkg::t_ctr r_mem [gcp_pkg::TABLE_DEPTH];
    gcp_pkg::t_ctr r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/gcp_checker.sv
// port-level checks of the predictor, bound to the top level
`include "gshare_counter_predictor_core_defines.svh"

module gcp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [gcp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready
);

    // a stalled result beat stays and keeps its payload
    `GCP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // one item at a time: no input beat right after an accepted one
    `GCP_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a taken prediction needs a counter above some threshold, so not zero
    `GCP_ASSERT_NOW(a_taken_nonzero, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[8:1] != 8'd0)

    // configuration writes are never back-pressured
    `GCP_ASSERT_NOW(a_cfg_ready, i_cfg_valid, o_cfg_ready)

endmodule

bind gshare_counter_predictor_core gcp_checker u_gcp_checker (.*);
